// ===== rtl/core/bpfa_pkg.sv =====
// shared types, constants and helper functions of the page frame allocator
`timescale 1ns / 1ps

package bpfa_pkg;

    // fixed field widths
    localparam int FRAME_W = 40;
    localparam int PAGES_W = 13;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 3;

    // area limits and defaults
    localparam int MAX_AREAS          = 4;
    localparam int DEF_AREAS          = 4;
    localparam int DEF_PAGES_PER_AREA = 'h1000;
    localparam int CFG_REGS           = 8;

    // request codes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // result codes
    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_FREE      = 2'd1,
        STAT_NO_AREA      = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AREA0_BASE  = 3'd0,
        REG_AREA0_PAGES = 3'd1,
        REG_AREA1_BASE  = 3'd2,
        REG_AREA1_PAGES = 3'd3,
        REG_AREA2_BASE  = 3'd4,
        REG_AREA2_PAGES = 3'd5,
        REG_AREA3_BASE  = 3'd6,
        REG_AREA3_PAGES = 3'd7
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_AREA,
        S_A_WORD,
        S_F_AREA,
        S_F_BIT,
        S_EMIT
    } state_t;

    // one area as seen by the sequencer, pages already clamped
    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [PAGES_W-1:0] pages;
    } area_cfg_t;

    // index width that never collapses to zero bits
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // position of the lowest clear bit of a bitmap word
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/bpfa_mem.sv =====
// bitmap store: one write port, one read port, registered read data
`timescale 1ns / 1ps

module bpfa_mem
    import bpfa_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = idx_width(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bpfa_cfg.sv =====
// area configuration registers with page count clamping
`timescale 1ns / 1ps

module bpfa_cfg
    import bpfa_pkg::*;
#(
    parameter int PAGES_PER_AREA = DEF_PAGES_PER_AREA
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output area_cfg_t            areas [MAX_AREAS]
);

    localparam logic [16:0] PPA_LIM = 17'(PAGES_PER_AREA);

    logic [FRAME_W-1:0] base_reg  [MAX_AREAS];
    logic [PAGES_W-1:0] pages_reg [MAX_AREAS];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_AREAS; i++)
            begin
                base_reg[i]  <= '0;
                pages_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AREA0_BASE:  base_reg[0]  <= cfg_data[FRAME_W-1:0];
                REG_AREA0_PAGES: pages_reg[0] <= cfg_data[PAGES_W-1:0];
                REG_AREA1_BASE:  base_reg[1]  <= cfg_data[FRAME_W-1:0];
                REG_AREA1_PAGES: pages_reg[1] <= cfg_data[PAGES_W-1:0];
                REG_AREA2_BASE:  base_reg[2]  <= cfg_data[FRAME_W-1:0];
                REG_AREA2_PAGES: pages_reg[2] <= cfg_data[PAGES_W-1:0];
                REG_AREA3_BASE:  base_reg[3]  <= cfg_data[FRAME_W-1:0];
                REG_AREA3_PAGES: pages_reg[3] <= cfg_data[PAGES_W-1:0];
                default:         ;
            endcase
        end
    end

    // page count limited to the bitmap size of one area
    always_comb
    begin
        for (int i = 0; i < MAX_AREAS; i++)
        begin
            areas[i].base  = base_reg[i];
            areas[i].pages = ({4'b0, pages_reg[i]} > PPA_LIM) ?
                             PAGES_W'(PAGES_PER_AREA) : pages_reg[i];
        end
    end

endmodule

// ===== rtl/core/bpfa_ctrl.sv =====
// request sequencer: bitmap scan, read-modify-write, used counters, output word
`timescale 1ns / 1ps

module bpfa_ctrl
    import bpfa_pkg::*;
#(
    parameter int AREAS          = DEF_AREAS,
    parameter int PAGES_PER_AREA = DEF_PAGES_PER_AREA,
    localparam int WPA   = (PAGES_PER_AREA + WORD_W - 1) / WORD_W,
    localparam int DEPTH = AREAS * WPA,
    localparam int AW    = idx_width(DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [FRAME_W-1:0] page_frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FRAME_W-1:0] frame_out,
    output logic [1:0]         status,
    input  area_cfg_t          areas [MAX_AREAS],
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [WORD_W-1:0]  mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  logic [WORD_W-1:0]  mem_rdata
);

    localparam int AIW   = idx_width(AREAS);
    localparam int WW    = idx_width(WPA);
    localparam int IDX_W = WW + BIT_W;
    localparam int CW    = (IDX_W > PAGES_W) ? IDX_W : PAGES_W;
    localparam int SW    = (IDX_W + 1 > PAGES_W) ? IDX_W + 1 : PAGES_W;

    state_t             state_reg, state_next;
    logic [AIW-1:0]     area_reg, area_next;
    logic [WW-1:0]      word_reg, word_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [FRAME_W-1:0] frame_in_reg, frame_in_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0] frame_out_reg, frame_out_next;
    status_t            status_reg, status_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [PAGES_W-1:0] used_reg [AREAS];
    logic               cnt_we;
    logic [PAGES_W-1:0] cnt_next;

    area_cfg_t          cur;
    logic [PAGES_W-1:0] cnt;
    logic               last_area;
    logic               rd_full;
    logic [BIT_W-1:0]   zero_bit;
    logic [IDX_W-1:0]   alloc_idx;
    logic               alloc_ok;
    logic [WW:0]        next_word;
    logic               next_beyond;
    logic [FRAME_W-1:0] diff;
    logic               in_range;

    // word address of a bitmap word inside an area
    function automatic logic [AW-1:0] word_addr(input logic [AIW-1:0] a,
                                                input logic [WW-1:0] w);
        return AW'(int'(a) * WPA + int'(w));
    endfunction

    // views of the current area
    assign cur       = areas[area_reg];
    assign cnt       = used_reg[area_reg];
    assign last_area = (area_reg == AIW'(AREAS - 1));

    // allocate: lowest clear bit of the word just read
    assign rd_full     = &mem_rdata;
    assign zero_bit    = lowest_zero(mem_rdata);
    assign alloc_idx   = {word_reg, zero_bit};
    assign alloc_ok    = (CW'(alloc_idx) < CW'(cur.pages));
    assign next_word   = {1'b0, word_reg} + 1'b1;
    assign next_beyond = (SW'({next_word, {BIT_W{1'b0}}}) >= SW'(cur.pages));

    // free: range check without wrap
    assign diff     = frame_in_reg - cur.base;
    assign in_range = (frame_in_reg >= cur.base) && (diff < FRAME_W'(cur.pages));

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        area_next       = area_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        frame_in_next   = frame_in_reg;
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        frame_out_next  = frame_out_reg;
        status_next     = status_reg;
        cnt_we          = 1'b0;
        cnt_next        = cnt;
        mem_we          = 1'b0;
        mem_waddr       = word_addr(area_reg, word_reg);
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = word_addr(area_reg, word_reg);

        // output word taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    frame_in_next = page_frame;
                    area_next     = '0;
                    state_next    = (op_t'(operation) == OP_FREE) ? S_F_AREA : S_A_AREA;
                end
            end

            // skip full areas, else start the word scan
            S_A_AREA:
            begin
                if (cnt < cur.pages)
                begin
                    word_next  = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = word_addr(area_reg, '0);
                    state_next = S_A_WORD;
                end
                else if (last_area)
                begin
                    res_frame_next  = '0;
                    res_status_next = STAT_NO_FREE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    area_next = area_reg + 1'b1;
                end
            end

            // one bitmap word per cycle
            S_A_WORD:
            begin
                if (!rd_full && alloc_ok)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = mem_rdata | (WORD_W'(1) << zero_bit);
                    cnt_we          = 1'b1;
                    cnt_next        = cnt + 1'b1;
                    res_frame_next  = cur.base + FRAME_W'(alloc_idx);
                    res_status_next = STAT_OK;
                    state_next      = S_EMIT;
                end
                else if (rd_full && !next_beyond)
                begin
                    word_next = next_word[WW-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = word_addr(area_reg, next_word[WW-1:0]);
                end
                else if (last_area)
                begin
                    res_frame_next  = '0;
                    res_status_next = STAT_NO_FREE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    area_next  = area_reg + 1'b1;
                    state_next = S_A_AREA;
                end
            end

            // find the area holding the frame
            S_F_AREA:
            begin
                if (in_range)
                begin
                    word_next  = diff[IDX_W-1:BIT_W];
                    bit_next   = diff[BIT_W-1:0];
                    mem_re     = 1'b1;
                    mem_raddr  = word_addr(area_reg, diff[IDX_W-1:BIT_W]);
                    state_next = S_F_BIT;
                end
                else if (last_area)
                begin
                    res_frame_next  = '0;
                    res_status_next = STAT_NO_AREA;
                    state_next      = S_EMIT;
                end
                else
                begin
                    area_next = area_reg + 1'b1;
                end
            end

            // clear the page bit unless it is already clear
            S_F_BIT:
            begin
                if (!mem_rdata[bit_reg])
                begin
                    res_frame_next  = '0;
                    res_status_next = STAT_ALREADY_FREE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = mem_rdata & ~(WORD_W'(1) << bit_reg);
                    cnt_we          = (cnt != '0);
                    cnt_next        = cnt - 1'b1;
                    res_frame_next  = frame_in_reg;
                    res_status_next = STAT_OK;
                end
                state_next = S_EMIT;
            end

            // hand the result to the output register
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    frame_out_next = res_frame_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AREAS; i++)
            begin
                used_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                used_reg[area_reg] <= cnt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        area_reg       <= area_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        frame_in_reg   <= frame_in_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        frame_out_reg  <= frame_out_next;
        status_reg     <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign frame_out = frame_out_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/core/bitmap_page_frame_allocator_core.sv =====
// Allocate: areas are scanned in order, full ones skipped, one bitmap word per memory read
// (256 words of bitmap in the default build), then one read-modify-write sets the bit.
// Free: one area range check per cycle, one read-modify-write.
// One word in work at a time: intake reopens in the cycle after a result is registered.
// After reset a clearing pass writes every bitmap word to zero; no word is taken meanwhile,
// configuration writes are.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
#(
    parameter int AREAS          = DEF_AREAS,
    parameter int PAGES_PER_AREA = DEF_PAGES_PER_AREA
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [FRAME_W-1:0]   page_frame,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [FRAME_W-1:0]   frame_out,
    output logic [1:0]           status
);

    localparam int WPA   = (PAGES_PER_AREA + WORD_W - 1) / WORD_W;
    localparam int DEPTH = AREAS * WPA;
    localparam int AW    = idx_width(DEPTH);

    area_cfg_t         areas [MAX_AREAS];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    // area registers
    bpfa_cfg #(
        .PAGES_PER_AREA (PAGES_PER_AREA)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .areas     (areas)
    );

    // page bitmap
    bpfa_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request sequencer
    bpfa_ctrl #(
        .AREAS          (AREAS),
        .PAGES_PER_AREA (PAGES_PER_AREA)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .page_frame (page_frame),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_out  (frame_out),
        .status     (status),
        .areas      (areas),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

endmodule

// ===== rtl/core/bpfa_checker.sv =====
// port-level checks of the allocator and their binding to the top level
`timescale 1ns / 1ps

module bpfa_props
    import bpfa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [FRAME_W-1:0] frame_out,
    input logic [1:0]         status
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_out) && $stable(status))
        else $error("stalled result word changed");

    // every failure reports frame zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> (frame_out == '0))
        else $error("failure word carries a frame");

    // one word in work: intake closes right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while one is in work");

    // a taken word cannot produce its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind bitmap_page_frame_allocator_core bpfa_props u_bpfa_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_out (frame_out),
    .status    (status)
);

// ===== verif/bpfa_checker.sv =====
// reply predictor and comparator for the page frame allocator core
`timescale 1ns / 1ps

module bpfa_checker
    import bpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 operation,
    input  logic [FRAME_W-1:0]   page_frame,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [FRAME_W-1:0]   frame_out,
    input  logic [1:0]           status,
    output int                   replies_pending,
    output int                   error_count
);

    localparam int AREA_N = DEF_AREAS;
    localparam int PAGE_N = DEF_PAGES_PER_AREA;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        status_t            stat;
    } reply_t;

    // shadow copy of the area registers and the allocation state
    logic [FRAME_W-1:0] area_base  [MAX_AREAS];
    logic [PAGES_W-1:0] area_pages [MAX_AREAS];
    logic [PAGES_W-1:0] used_pages [AREA_N];
    bit                 page_taken [AREA_N][PAGE_N];
    reply_t             reply_queue [$];
    reply_t             oldest;

    // register write into the shadow copy
    function automatic void write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_AREA0_BASE:  area_base[0]  = data[FRAME_W-1:0];
            REG_AREA0_PAGES: area_pages[0] = data[PAGES_W-1:0];
            REG_AREA1_BASE:  area_base[1]  = data[FRAME_W-1:0];
            REG_AREA1_PAGES: area_pages[1] = data[PAGES_W-1:0];
            REG_AREA2_BASE:  area_base[2]  = data[FRAME_W-1:0];
            REG_AREA2_PAGES: area_pages[2] = data[PAGES_W-1:0];
            REG_AREA3_BASE:  area_base[3]  = data[FRAME_W-1:0];
            REG_AREA3_PAGES: area_pages[3] = data[PAGES_W-1:0];
            default: ;
        endcase
    endfunction

    // page count as the block uses it, clamped to the bitmap size
    function automatic int page_limit(input int a);
        return (area_pages[a] > PAGE_N) ? PAGE_N : int'(area_pages[a]);
    endfunction

    // expected reply for one request, updating the shadow bitmap
    function automatic reply_t predict_reply(input logic op, input logic [FRAME_W-1:0] frame);
        reply_t           r;
        int               lim;
        int               idx;
        logic [FRAME_W:0] offset;
        r.frame = '0;
        r.stat  = (op == OP_FREE) ? STAT_NO_AREA : STAT_NO_FREE;
        for (int a = 0; a < AREA_N; a++)
        begin
            lim = page_limit(a);
            if (op == OP_ALLOC)
            begin
                // first area below its limit with a clear bit under the page count
                idx = -1;
                if (used_pages[a] < lim)
                begin
                    for (int i = 0; i < lim && idx < 0; i++)
                    begin
                        if (!page_taken[a][i])
                        begin
                            idx = i;
                        end
                    end
                end
                if (idx >= 0)
                begin
                    page_taken[a][idx] = 1'b1;
                    used_pages[a]      = used_pages[a] + 1'b1;
                    r.frame            = area_base[a] + FRAME_W'(idx);
                    r.stat             = STAT_OK;
                    return r;
                end
            end
            else
            begin
                // range check without wrap past the top frame number
                offset = {1'b0, frame} - {1'b0, area_base[a]};
                if (frame >= area_base[a] && offset < (FRAME_W + 1)'(lim))
                begin
                    idx = int'(offset[PAGES_W-1:0]);
                    if (!page_taken[a][idx])
                    begin
                        r.stat = STAT_ALREADY_FREE;
                        return r;
                    end
                    page_taken[a][idx] = 1'b0;
                    if (used_pages[a] != '0)
                    begin
                        used_pages[a] = used_pages[a] - 1'b1;
                    end
                    r.frame = frame;
                    r.stat  = STAT_OK;
                    return r;
                end
            end
        end
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            // shadow state follows the block's reset
            for (int a = 0; a < MAX_AREAS; a++)
            begin
                area_base[a]  = '0;
                area_pages[a] = '0;
            end
            for (int a = 0; a < AREA_N; a++)
            begin
                used_pages[a] = '0;
                for (int i = 0; i < PAGE_N; i++)
                begin
                    page_taken[a][i] = 1'b0;
                end
            end
            reply_queue.delete();
            replies_pending = 0;
            error_count     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                write_register(cfg_reg_t'(cfg_index), cfg_data);
            end
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual frame %h status %0d",
                             $time, frame_out, status);
                    error_count++;
                end
                else
                begin
                    oldest = reply_queue.pop_front();
                    if (frame_out !== oldest.frame)
                    begin
                        $display("%0t: frame_out mismatch, expected %h, actual %h",
                                 $time, oldest.frame, frame_out);
                        error_count++;
                    end
                    if (status !== oldest.stat)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, oldest.stat, status);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                reply_queue.push_back(predict_reply(operation, page_frame));
            end
            replies_pending = reply_queue.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// stimulus and verdict for the page frame allocator core
`timescale 1ns / 1ps

module tb
    import bpfa_pkg::*;
();

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 144;
    localparam int DRAIN_CYCLES  = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [FRAME_W-1:0]   page_frame;
    logic                 out_valid;
    logic                 out_stall;
    logic [FRAME_W-1:0]   frame_out;
    logic [1:0]           status;
    int                   replies_pending;
    int                   error_count;

    // no idling on either side while set
    bit                   steady;

    // area settings as last written, used to aim free requests
    logic [FRAME_W-1:0]   base_of  [MAX_AREAS];
    logic [PAGES_W-1:0]   pages_of [MAX_AREAS];
    cfg_reg_t base_reg  [MAX_AREAS] = '{REG_AREA0_BASE, REG_AREA1_BASE,
                                        REG_AREA2_BASE, REG_AREA3_BASE};
    cfg_reg_t pages_reg [MAX_AREAS] = '{REG_AREA0_PAGES, REG_AREA1_PAGES,
                                        REG_AREA2_PAGES, REG_AREA3_PAGES};

    bitmap_page_frame_allocator_core uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .page_frame (page_frame),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_out  (frame_out),
        .status     (status)
    );

    bpfa_checker reply_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .page_frame      (page_frame),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_out       (frame_out),
        .status          (status),
        .replies_pending (replies_pending),
        .error_count     (error_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls at random
    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < 23);
    end

    // run limit
    initial
    begin
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [FRAME_W-1:0] any_frame();
        return FRAME_W'({$urandom, $urandom});
    endfunction

    // write all area registers, junk above the page count field is dropped
    task automatic load_areas();
        for (int a = 0; a < MAX_AREAS; a++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= base_reg[a];
            cfg_data  <= base_of[a];
            @(negedge clk);
            cfg_index <= pages_reg[a];
            cfg_data  <= {($urandom_range(0, 1) ? (CFG_W - PAGES_W)'($urandom) :
                                                  (CFG_W - PAGES_W)'(0)), pages_of[a]};
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // drop valid and wait until every reply has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // present one request word and hold it until taken
    task automatic send_word(input op_t op, input logic [FRAME_W-1:0] frame);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        page_frame <= frame;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // new area layout; small pools often so areas fill and overlap
    task automatic pick_areas(input bit small_only);
        int r;
        for (int a = 0; a < MAX_AREAS; a++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                base_of[a] = FRAME_W'($urandom_range(0, 48));
            else if (r < 7)
                base_of[a] = any_frame();
            else if (r == 7)
                base_of[a] = '0;
            else if (r == 8)
                base_of[a] = '1;
            else
                base_of[a] = '1 - FRAME_W'($urandom_range(0, 16));
            r = small_only ? $urandom_range(0, 6) : $urandom_range(0, 9);
            if (r < 6)
                pages_of[a] = PAGES_W'($urandom_range(1, small_only ? 12 : 24));
            else if (r == 6)
                pages_of[a] = '0;
            else if (r == 7)
                pages_of[a] = PAGES_W'(DEF_PAGES_PER_AREA);
            else if (r == 8)
                pages_of[a] = '1;
            else
                pages_of[a] = PAGES_W'($urandom);
        end
        load_areas();
    endtask

    // one random request: mostly allocations and frees aimed at an area
    task automatic random_word();
        int                 pick;
        int                 a;
        int                 span;
        logic [FRAME_W-1:0] f;
        pick = $urandom_range(0, 99);
        a    = $urandom_range(0, MAX_AREAS - 1);
        span = (pages_of[a] > 64) ? 64 : int'(pages_of[a]) + 1;
        if (pick < 55)
        begin
            send_word(OP_ALLOC, any_frame());
        end
        else if (pick < 90)
        begin
            // offset zero lands just below the base
            f = base_of[a] + FRAME_W'($urandom_range(0, span)) - 1'b1;
            send_word(OP_FREE, f);
        end
        else
        begin
            send_word(OP_FREE, any_frame());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_AREA0_BASE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        operation  = OP_ALLOC;
        page_frame = '0;
        steady     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: wrap at the top frame, disabled area, clamped page count
        base_of[0] = '0;                 pages_of[0] = 13'd3;
        base_of[1] = 40'hFF_FFFF_FFFE;   pages_of[1] = 13'd4;
        base_of[2] = 40'h100;            pages_of[2] = '0;
        base_of[3] = 40'h1000;           pages_of[3] = '1;
        load_areas();
        send_word(OP_FREE, 40'h0);
        repeat (3) send_word(OP_ALLOC, '0);
        repeat (4) send_word(OP_ALLOC, '1);
        send_word(OP_ALLOC, any_frame());
        send_word(OP_FREE, 40'h1);
        send_word(OP_ALLOC, '0);
        send_word(OP_FREE, 40'h100);
        send_word(OP_FREE, 40'hFF_FFFF_FFFF);
        send_word(OP_FREE, 40'hFF_FFFF_FFFF);
        send_word(OP_FREE, 40'h1FFF);
        send_word(OP_FREE, 40'h2000);
        send_word(OP_FREE, 40'h1000);
        send_word(OP_FREE, 40'h1000);
        wait_idle();

        // every area disabled: nothing to allocate and nothing to free
        for (int a = 0; a < MAX_AREAS; a++)
        begin
            pages_of[a] = '0;
        end
        load_areas();
        send_word(OP_ALLOC, '1);
        send_word(OP_FREE, 40'h0);
        send_word(OP_FREE, '1);
        wait_idle();

        // random phases, each starting from an idle block
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            steady = (ph == 2);
            pick_areas(ph[0] == 1'b0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                random_word();
            end
            wait_idle();
        end
        steady = 1'b0;

        // drain, then give late words a chance to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== bitmap_page_frame_allocator_core.f =====
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_mem.sv
rtl/core/bpfa_cfg.sv
rtl/core/bpfa_ctrl.sv
rtl/core/bitmap_page_frame_allocator_core.sv
rtl/core/bpfa_checker.sv
verif/bpfa_checker.sv
verif/tb.sv
